// ===== hdl/fct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fct_pkg;

   localparam int FLOW_CAPACITY = 64;
   localparam int COUNT_W       = 64;
   localparam int LIMIT_W       = 7;
   localparam int RD_SLOT_W     = 6;
   localparam int OUT_SLOT_W    = 6;
   localparam int SLOT_W        = (FLOW_CAPACITY > 1) ? $clog2(FLOW_CAPACITY) : 1;
   localparam int USED_W        = $clog2(FLOW_CAPACITY + 1);
   localparam int LIM_CMP_W     = (USED_W > LIMIT_W) ? USED_W : LIMIT_W;
   localparam int IDX_CMP_W     = (SLOT_W > RD_SLOT_W) ? SLOT_W : RD_SLOT_W;

   typedef enum logic [1:0] {
      OP_FLOW  = 2'd0,
      OP_OTHER = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_HIT   = 3'd0,
      ST_NEW   = 3'd1,
      ST_DROP  = 3'd2,
      ST_OTHER = 3'd3,
      ST_READ  = 3'd4
   } status_type;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  protocol;
   } key_type;

   typedef struct packed {
      logic [1:0]           op;
      logic [31:0]          src_addr;
      logic [31:0]          dst_addr;
      logic [15:0]          src_port;
      logic [15:0]          dst_port;
      logic [7:0]           protocol;
      logic [RD_SLOT_W-1:0] read_slot;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [OUT_SLOT_W-1:0] slot;
      logic [COUNT_W-1:0]    count;
      logic [COUNT_W-1:0]    other_total;
      logic                  entry_valid;
      logic [31:0]           key_src_addr;
      logic [31:0]           key_dst_addr;
      logic [15:0]           key_src_port;
      logic [15:0]           key_dst_port;
      logic [7:0]            key_protocol;
   } rsp_type;

   // Token that walks the cell row: search key on the way in, read-back key on a read.
   typedef struct packed {
      logic                 live;
      op_type               op;
      key_type              key;
      logic [RD_SLOT_W-1:0] read_slot;
      logic                 hit;
      logic                 ins;
      logic [SLOT_W-1:0]    slot;
      logic [COUNT_W-1:0]   count;
   } tok_type;

endpackage
`default_nettype wire

// ===== hdl/fct_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fct_cell
   import fct_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [SLOT_W-1:0] cell_idx,
   input  wire logic [USED_W-1:0] used,
   input  wire logic              can_insert,
   input  wire tok_type           tok_up,
   output tok_type                tok_down
);

   key_type            key_ff, key_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   tok_type            tok_ff, tok_in;
   logic               claimed, at_free, rd_match;

   assign claimed  = USED_W'(cell_idx) < used;
   assign at_free  = USED_W'(cell_idx) == used;
   assign rd_match = IDX_CMP_W'(cell_idx) == IDX_CMP_W'(tok_up.read_slot);

   always_comb begin
      tok_in   = tok_up;
      key_in   = key_ff;
      count_in = count_ff;
      if (tok_up.live) begin
         unique case (tok_up.op)
            OP_FLOW: begin
               if (!tok_up.hit && !tok_up.ins && claimed && key_ff == tok_up.key) begin
                  count_in     = count_ff + COUNT_W'(1);
                  tok_in.hit   = 1'b1;
                  tok_in.slot  = cell_idx;
                  tok_in.count = count_ff + COUNT_W'(1);
               end else if (!tok_up.hit && !tok_up.ins && at_free && can_insert) begin
                  // first free slot: claim it
                  key_in       = tok_up.key;
                  count_in     = COUNT_W'(1);
                  tok_in.ins   = 1'b1;
                  tok_in.slot  = cell_idx;
                  tok_in.count = COUNT_W'(1);
               end
            end
            OP_READ: begin
               if (claimed && rd_match) begin
                  tok_in.hit   = 1'b1;
                  tok_in.key   = key_ff;
                  tok_in.count = count_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      count_ff <= count_in;
      if (reset) begin
         tok_ff.live <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_down = tok_ff;

endmodule
`default_nettype wire

// ===== hdl/flow_counter_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Exact-match flow counter table. Slots live in a row of FLOW_CAPACITY cells,
// each holding one flow key and its 64-bit packet count. An accepted item becomes
// a token that walks the row one cell per clock: a count item (op 0) bumps the
// cell whose key matches, or claims the first free slot if none matched and the
// limit allows, else the flow is dropped; a read item (op 2) picks up the key
// and count of the slot it names; a non-IPv4 item (op 1) only bumps the shared
// counter. The token passes through every cell register before its result
// appears, and the next item is taken only after the token leaves the row, so
// the block holds one item at a time. Op 3 is accepted and gives no result. A
// finished result sits in an output register with a one-entry skid behind it,
// so the block keeps working while the result side stalls, until the skid
// entry is full. flow_limit (csr_wdata, reset 64) caps the claimed slots;
// write it only while the block is idle.
module flow_counter_table
   import fct_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_data,
   input  wire logic               csr_we,
   input  wire logic [LIMIT_W-1:0] csr_wdata
);

   logic [LIMIT_W-1:0] limit_ff;
   logic [USED_W-1:0]  used_ff, used_in;
   logic [COUNT_W-1:0] other_ff, other_in;
   logic               busy_ff, busy_in;
   rsp_type            rsp_ff, rsp_in, skid_ff, skid_in, res;
   logic               rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;
   logic               can_insert, accept, launch, exit_live, pop, rsp_free, found;
   tok_type            chain [0:FLOW_CAPACITY];
   tok_type            head;
   tok_type            x;

   // Hold off new items while a token walks the row or the skid stage is full.
   assign req_ready = !busy_ff && !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign launch    = accept && (op_type'(req_data.op) != OP_NONE);

   assign can_insert = (used_ff < USED_W'(FLOW_CAPACITY)) &&
                       (LIM_CMP_W'(used_ff) < LIM_CMP_W'(limit_ff));

   // Build the token at the head of the row.
   always_comb begin
      head              = '0;
      head.live         = launch;
      head.op           = op_type'(req_data.op);
      head.key.src_addr = req_data.src_addr;
      head.key.dst_addr = req_data.dst_addr;
      head.key.src_port = req_data.src_port;
      head.key.dst_port = req_data.dst_port;
      head.key.protocol = req_data.protocol;
      head.read_slot    = req_data.read_slot;
   end

   assign chain[0] = head;

   for (genvar g = 0; g < FLOW_CAPACITY; g++) begin : g_cell
      fct_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (SLOT_W'(g)),
         .used       (used_ff),
         .can_insert (can_insert),
         .tok_up     (chain[g]),
         .tok_down   (chain[g+1])
      );
   end

   assign x         = chain[FLOW_CAPACITY];
   assign exit_live = x.live;
   assign found     = x.hit || x.ins;

   // Turn the token leaving the row into a result and the new totals.
   always_comb begin
      used_in  = used_ff;
      other_in = other_ff;
      res      = '0;
      if (exit_live && x.op == OP_FLOW && x.ins) begin
         used_in = used_ff + USED_W'(1);
      end
      if (exit_live && x.op == OP_OTHER) begin
         other_in = other_ff + COUNT_W'(1);
      end
      res.other_total = other_in;
      unique case (x.op)
         OP_FLOW: begin
            if (x.hit) begin
               res.status = ST_HIT;
            end else if (x.ins) begin
               res.status = ST_NEW;
            end else begin
               res.status = ST_DROP;
            end
            res.entry_valid = found;
            res.slot        = found ? OUT_SLOT_W'(x.slot) : '0;
            res.count       = found ? x.count : '0;
         end
         OP_OTHER: begin
            res.status = ST_OTHER;
         end
         OP_READ: begin
            res.status      = ST_READ;
            res.slot        = OUT_SLOT_W'(x.read_slot);
            res.entry_valid = x.hit;
            if (x.hit) begin
               res.count        = x.count;
               res.key_src_addr = x.key.src_addr;
               res.key_dst_addr = x.key.dst_addr;
               res.key_src_port = x.key.src_port;
               res.key_dst_port = x.key.dst_port;
               res.key_protocol = x.key.protocol;
            end
         end
         default: begin
         end
      endcase
   end

   // Output register with a one-entry skid stage behind it.
   assign pop      = rsp_valid_ff && rsp_ready;
   assign rsp_free = !rsp_valid_ff || pop;

   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      priority if (skid_valid_ff && rsp_free) begin
         rsp_in        = skid_ff;
         rsp_valid_in  = 1'b1;
         skid_valid_in = 1'b0;
      end else if (exit_live && rsp_free) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end else if (exit_live) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (launch) begin
         busy_in = 1'b1;
      end else if (exit_live) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
      if (reset) begin
         limit_ff      <= LIMIT_W'(64);
         used_ff       <= '0;
         other_ff      <= '0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         used_ff       <= used_in;
         other_ff      <= other_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid stage holds an item while the output register is empty");

   a_exit_while_busy: assert property (@(posedge clock) disable iff (reset)
      exit_live |-> busy_ff)
      else $error("token left the cell row with no item in flight");

   a_used_in_range: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(FLOW_CAPACITY))
      else $error("claimed slot count beyond capacity");

   a_launch_sets_busy: assert property (@(posedge clock) disable iff (reset)
      launch |=> busy_ff)
      else $error("accepted item did not mark the row busy");

endmodule
`default_nettype wire

// ===== tb/flow_table_checker.sv =====
`timescale 1ns / 1ps
module flow_table_checker
   import fct_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  req_type            req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  rsp_type            rsp_data,
   input  logic               csr_we,
   input  logic [LIMIT_W-1:0] csr_wdata,
   output int                 mismatches,
   output int                 pending,
   output int                 checked
);

   key_type              flow_keys [FLOW_CAPACITY];
   logic [COUNT_W-1:0]   flow_counts [FLOW_CAPACITY];
   int                   used_slots;
   logic [COUNT_W-1:0]   nonip_count;
   logic [LIMIT_W-1:0]   flow_limit;
   rsp_type              owed_rsps [$];
   rsp_type              want;

   function automatic rsp_type count_and_lookup(req_type item);
      rsp_type r;
      key_type k;
      int      found;
      int      cap;
      r     = '0;
      k     = {item.src_addr, item.dst_addr, item.src_port, item.dst_port, item.protocol};
      cap   = (int'(flow_limit) < FLOW_CAPACITY) ? int'(flow_limit) : FLOW_CAPACITY;
      found = -1;
      case (op_type'(item.op))
         OP_FLOW: begin
            for (int i = 0; i < used_slots; i++)
               if (found < 0 && flow_keys[i] == k) found = i;
            if (found >= 0) begin
               flow_counts[found] = flow_counts[found] + 64'd1;
               r.status      = ST_HIT;
               r.slot        = OUT_SLOT_W'(found);
               r.count       = flow_counts[found];
               r.entry_valid = 1'b1;
            end else if (used_slots < cap) begin
               flow_keys[used_slots]   = k;
               flow_counts[used_slots] = 64'd1;
               r.status      = ST_NEW;
               r.slot        = OUT_SLOT_W'(used_slots);
               r.count       = 64'd1;
               r.entry_valid = 1'b1;
               used_slots++;
            end else begin
               r.status = ST_DROP;
            end
         end
         OP_OTHER: begin
            nonip_count = nonip_count + 64'd1;
            r.status    = ST_OTHER;
         end
         default: begin
            // read; the unused op never reaches here
            r.status = ST_READ;
            r.slot   = item.read_slot;
            if (int'(item.read_slot) < used_slots) begin
               r.entry_valid  = 1'b1;
               r.count        = flow_counts[item.read_slot];
               r.key_src_addr = flow_keys[item.read_slot].src_addr;
               r.key_dst_addr = flow_keys[item.read_slot].dst_addr;
               r.key_src_port = flow_keys[item.read_slot].src_port;
               r.key_dst_port = flow_keys[item.read_slot].dst_port;
               r.key_protocol = flow_keys[item.read_slot].protocol;
            end
         end
      endcase
      r.other_total = nonip_count;
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         owed_rsps.delete();
         used_slots  = 0;
         nonip_count = '0;
         flow_limit  = LIMIT_W'(FLOW_CAPACITY);
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_rsps.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual %h", $time, rsp_data);
               mismatches++;
            end else begin
               want = owed_rsps.pop_front();
               check_field("status", want.status, rsp_data.status);
               check_field("slot", want.slot, rsp_data.slot);
               check_field("count", want.count, rsp_data.count);
               check_field("other_total", want.other_total, rsp_data.other_total);
               check_field("entry_valid", want.entry_valid, rsp_data.entry_valid);
               check_field("key_src_addr", want.key_src_addr, rsp_data.key_src_addr);
               check_field("key_dst_addr", want.key_dst_addr, rsp_data.key_dst_addr);
               check_field("key_src_port", want.key_src_port, rsp_data.key_src_port);
               check_field("key_dst_port", want.key_dst_port, rsp_data.key_dst_port);
               check_field("key_protocol", want.key_protocol, rsp_data.key_protocol);
               checked++;
            end
         end
         if (req_valid && req_ready && op_type'(req_data.op) != OP_NONE)
            owed_rsps.push_back(count_and_lookup(req_data));
         if (csr_we)
            flow_limit = csr_wdata;
      end
      pending = owed_rsps.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Flow counter table bench: drives count, non-IPv4, read and unused items through
// the request channel, lets a side checker predict every result, and gives the verdict.
module tb;
   import fct_pkg::*;

   localparam int     HALF_PERIOD    = 4;
   localparam int     RESET_CYCLES   = 6;
   // one item walks the whole cell row; leave some margin
   localparam int     SETTLE_CYCLES  = 80;
   localparam int     HOLDOFF_CYCLES = 600;
   localparam int     POOL_SIZE      = 96;
   localparam int     PHASE_ITEMS    = 380;
   // ~1550 items in all; the timeout is 8 ms
   localparam longint TIMEOUT_NS     = 64'd8_000_000;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_type            req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_type            rsp_data;
   logic               csr_we    = 1'b0;
   logic [LIMIT_W-1:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int checked;

   // idle percentages of each side, changed between phases
   int tx_idle_pct    = 26;
   int rx_idle_pct    = 57;
   // the receiver answers each hold-off request with one long stall
   int holdoff_asked  = 0;
   int holdoff_done   = 0;
   int items_sent     = 0;
   int limits_written = 0;

   // flows that recur, so that hits and slot claims both happen often
   key_type flow_pool [POOL_SIZE];

   flow_counter_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   flow_table_checker flow_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .mismatches (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   initial begin
      forever #HALF_PERIOD clock = ~clock;
   end

   initial begin
      #TIMEOUT_NS;
      $display("%0t: timeout with %0d results outstanding", $time, pending);
      $display("[flow_counter_table] ERROR");
      $finish;
   end

   // Result side: random back-pressure, plus a long stall whenever one is asked for.
   initial begin
      forever begin
         @(posedge clock);
         if (holdoff_asked != holdoff_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            holdoff_done++;
         end
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   function automatic key_type random_key();
      key_type k;
      k = {$urandom(), $urandom(), 16'($urandom()), 16'($urandom()), 8'($urandom())};
      return k;
   endfunction

   function automatic req_type make_item(op_type op, key_type k,
                                         logic [RD_SLOT_W-1:0] rd_slot);
      req_type item;
      item.op        = op;
      item.src_addr  = k.src_addr;
      item.dst_addr  = k.dst_addr;
      item.src_port  = k.src_port;
      item.dst_port  = k.dst_port;
      item.protocol  = k.protocol;
      item.read_slot = rd_slot;
      return item;
   endfunction

   // Mostly count items on recurring flows, some fresh flows, reads of any slot,
   // non-IPv4 packets and a few unused ops.
   function automatic req_type random_item();
      int unsigned pick;
      op_type      op;
      key_type     k;
      pick = $urandom_range(99);
      if (pick < 70)      op = OP_FLOW;
      else if (pick < 80) op = OP_OTHER;
      else if (pick < 95) op = OP_READ;
      else                op = OP_NONE;
      if ($urandom_range(4) == 0)      k = random_key();
      else if ($urandom_range(3) != 0) k = flow_pool[$urandom_range(31)];
      else                             k = flow_pool[$urandom_range(POOL_SIZE - 1)];
      return make_item(op, k, RD_SLOT_W'($urandom()));
   endfunction

   // Idle at random, then hold the item on the channel until it is taken.
   task automatic offer(req_type item);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Drop valid and wait for every outstanding result. The extra edge first lets the
   // checker record an item taken at the edge we were woken by.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Only touch the limit with the table idle.
   task automatic write_flow_limit(logic [LIMIT_W-1:0] value);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      limits_written++;
   endtask

   task automatic run_random(int count, int holdoff_at, int pause_at);
      for (int i = 0; i < count; i++) begin
         if (i == holdoff_at) holdoff_asked++;
         if (i == pause_at) drain();
         offer(random_item());
      end
   endtask

   initial begin
      key_type flow_a;
      key_type flow_b;
      foreach (flow_pool[i]) flow_pool[i] = random_key();
      flow_a = random_key();
      flow_b = random_key();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Limit of zero: nothing can be claimed, so a new flow is dropped and
      // every read sees an empty slot.
      write_flow_limit(7'd0);
      offer(make_item(OP_FLOW, '0, '0));
      offer(make_item(OP_OTHER, '0, '0));
      offer(make_item(OP_READ, '0, 6'd0));
      offer(make_item(OP_READ, '0, 6'd63));
      offer(make_item(OP_NONE, '0, '0));

      // Three slots: claim with the extreme keys, hit them, overflow, read back.
      write_flow_limit(7'd3);
      offer(make_item(OP_FLOW, '0, '0));
      offer(make_item(OP_FLOW, '1, '1));
      offer(make_item(OP_FLOW, '0, '0));
      offer(make_item(OP_FLOW, flow_a, '0));
      offer(make_item(OP_FLOW, flow_b, '0));
      offer(make_item(OP_FLOW, '1, '1));
      offer(make_item(OP_READ, '0, 6'd0));
      offer(make_item(OP_READ, '0, 6'd1));
      offer(make_item(OP_READ, '1, 6'd2));
      offer(make_item(OP_READ, '0, 6'd3));
      offer(make_item(OP_READ, '0, 6'd63));
      offer(make_item(OP_OTHER, '1, '1));
      offer(make_item(OP_NONE, '1, '1));

      // Limit lowered under the claimed count: old flows still count, new ones drop.
      write_flow_limit(7'd1);
      offer(make_item(OP_FLOW, flow_a, '0));
      offer(make_item(OP_FLOW, flow_b, '0));
      offer(make_item(OP_READ, '0, 6'd2));

      // Random phases, each at its own limit and idle mix.
      tx_idle_pct = 26;
      rx_idle_pct = 57;
      write_flow_limit(7'd20);
      run_random(PHASE_ITEMS, -1, -1);

      // Mid-phase, stop sending until every result is back.
      tx_idle_pct = 57;
      rx_idle_pct = 26;
      write_flow_limit(7'd45);
      run_random(PHASE_ITEMS, -1, PHASE_ITEMS / 2);

      // Limit above capacity; a long result stall backs the table up mid-phase.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_flow_limit(7'd127);
      run_random(PHASE_ITEMS, 100, -1);

      write_flow_limit(7'd64);
      run_random(PHASE_ITEMS, -1, -1);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d items and checked %0d results over %0d flow_limit writes (0 to 127).",
               items_sent, checked, limits_written);
      $display("Idle mixes 26/57, 57/26 and none; one long result stall, one full drain.");
      if (fail_count == 0 && pending == 0) begin
         $display("[flow_counter_table] OK");
      end else begin
         $display("[flow_counter_table] ERROR");
      end
      $finish;
   end

endmodule
